FILE: rtl/pfa_pkg.sv
// Shared constants, payload words and control structs for the partition fit allocator.
package pfa_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_BITS   = 32;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [CFG_IDX_BITS-1:0] REG_FIT_POLICY    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCKS_IN_USE = 1'd1;

  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef struct packed {
    logic        command;
    logic [3:0]  load_index;
    logic [15:0] size_value;
    logic        last_request;
  } in_word_t;

  typedef struct packed {
    logic       granted;
    logic [3:0] chosen_block;
    logic       last_result;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_request;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/pfa_ctrl.sv
// Sequencer for the allocator: accept, scan the table one entry a cycle, then report.
module pfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfa_pkg::dp_status_t status_i,
  output pfa_pkg::ctl_cmd_t   cmd_o
);
  import pfa_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.is_request) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/pfa_datapath.sv
// Free size table, configuration registers, scan registers and result register.
module pfa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfa_pkg::in_word_t                   in_word_i,
  input  logic                                cfg_we_i,
  input  logic [pfa_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [pfa_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  pfa_pkg::ctl_cmd_t                   cmd_i,
  output pfa_pkg::dp_status_t                 status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pfa_pkg::out_word_t                  out_word_o
);
  import pfa_pkg::*;

  logic [SIZE_BITS-1:0] table_q [NUM_BLOCKS];
  logic [1:0]           policy_q;
  logic [4:0]           blocks_q;

  logic [15:0]          req_size_q;
  logic                 req_last_q;
  logic [CNT_BITS-1:0]  k_q;
  logic                 found_q;
  logic [IDX_BITS-1:0]  pick_q;
  logic [SIZE_BITS-1:0] pick_val_q;

  logic                 out_valid_q;
  out_word_t            out_q;

  logic [CNT_BITS-1:0]  limit;
  logic [SIZE_BITS-1:0] cur_val;
  logic                 fits;
  logic                 better;
  logic                 stop_on_hit;
  logic                 load_ok;

  assign limit       = (int'(blocks_q) > NUM_BLOCKS) ? CNT_BITS'(NUM_BLOCKS)
                                                     : CNT_BITS'(blocks_q);
  assign cur_val     = table_q[k_q[IDX_BITS-1:0]];
  assign fits        = CMP_BITS'(cur_val) >= CMP_BITS'(req_size_q);
  assign stop_on_hit = (policy_q != POLICY_BEST) && (policy_q != POLICY_WORST);
  assign better      = !found_q
                    || ((policy_q == POLICY_BEST) && (cur_val < pick_val_q))
                    || ((policy_q == POLICY_WORST) && (cur_val > pick_val_q));
  assign load_ok     = int'(in_word_i.load_index) < NUM_BLOCKS;

  assign status_o.is_request = in_word_i.command == CMD_REQUEST;
  assign status_o.scan_done  = (k_q >= limit) || (found_q && stop_on_hit);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_FIRST;
      blocks_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIT_POLICY:    policy_q <= cfg_data_i[1:0];
        REG_BLOCKS_IN_USE: blocks_q <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // free size table: loads, and the decrement of the chosen entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        table_q[i] <= '0;
      end
    end else if (cmd_i.accept && (in_word_i.command == CMD_LOAD) && load_ok) begin
      table_q[IDX_BITS'(in_word_i.load_index)] <= SIZE_BITS'(in_word_i.size_value);
    end else if (cmd_i.finish && found_q) begin
      table_q[pick_q] <= pick_val_q - SIZE_BITS'(req_size_q);
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.accept) begin
      k_q     <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.step) begin
      k_q <= k_q + CNT_BITS'(1);
      if (fits) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_size_q <= in_word_i.size_value;
      req_last_q <= in_word_i.last_request;
    end
    if (cmd_i.step && fits && better) begin
      pick_q     <= k_q[IDX_BITS-1:0];
      pick_val_q <= cur_val;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.granted      <= found_q;
      out_q.chosen_block <= found_q ? 4'(pick_q) : 4'd0;
      out_q.last_result  <= req_last_q;
    end
  end

endmodule

FILE: rtl/partition_fit_allocator.sv
// Top level of the partition fit allocator: sequencer plus datapath.
//
// Input words arrive on in_valid_i/in_ready_o. A load word writes one entry
// of the 16-entry free size table and gives no result.
// A request word scans the table from index 0, one entry per cycle, under
// the fit_policy register (first, best or worst fit), then decrements the
// chosen entry and writes one result word to the output register.
// A request passes through an accept step, one scan step per entry read
// through the single-entry table read port (up to blocks_in_use, fewer
// when first fit hits early), a step to close the scan and an update step.
// Results leave on out_valid_o/out_ready_i from a register; the next word
// is accepted while a result waits. If the receiver stalls, a finished
// request holds in the final state until the register frees up.
// Configuration: cfg_we_i, cfg_idx_i (0 fit_policy, 1 blocks_in_use) and
// cfg_data_i, to be written by the user only while idle; the block has no check for it.
// Reset clears the table to zero, sets first fit and 16 blocks in use.
module partition_fit_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pfa_pkg::in_word_t                 in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pfa_pkg::out_word_t                out_word_o,
  input  logic                              cfg_we_i,
  input  logic [pfa_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [pfa_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import pfa_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
